### rtl/sfo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfo_pkg;

    localparam int NUM_DIRS    = 2;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0]  SYNC_BYTE       = 8'hFF;
    localparam logic [7:0]  MIN_LEN         = 8'd2;
    localparam logic [7:0]  MAX_LEN_RESET   = 8'd255;
    localparam logic [31:0] TIMEOUT_RESET   = 32'd5000;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(1);

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_BODY  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_OK      = 3'd1,
        EV_BADSUM  = 3'd2,
        EV_BADLEN  = 3'd3,
        EV_TIMEOUT = 3'd4
    } t_event;

    typedef struct packed {
        logic   dir;
        t_event code;
        logic   last;
    } t_result;

endpackage

`default_nettype wire

### rtl/servo_frame_observer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        in         i_in_valid / o_in_stall    i_req_type i_dir i_data_byte i_tick_time_us
// out       out        o_out_valid / i_out_stall  o_event_dir o_event_code o_last
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// One item per cycle while o_in_stall is low; state for both directions updates at the
// accepting edge and the results enter a four-entry result queue, so the first result shows
// in the next cycle. A tick that times out both directions puts two results in the queue,
// which drains one per cycle while i_out_stall is low. o_in_stall rises while three or more
// results wait. Synchronous active-low reset clears frame state, time, registers and the queue.

module servo_frame_observer_top
    import sfo_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire                   i_req_type,
    input  wire                   i_dir,
    input  wire  [7:0]            i_data_byte,
    input  wire  [63:0]           i_tick_time_us,

    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic                  o_event_dir,
    output logic [2:0]            o_event_code,
    output logic                  o_last,

    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    logic [7:0]         r_max_len;
    logic [31:0]        r_timeout;

    t_phase             r_phase [NUM_DIRS];
    t_phase             n_phase [NUM_DIRS];
    logic [7:0]         r_sum   [NUM_DIRS];
    logic [7:0]         n_sum   [NUM_DIRS];
    logic [7:0]         r_left  [NUM_DIRS];
    logic [7:0]         n_left  [NUM_DIRS];
    logic [63:0]        r_lbt   [NUM_DIRS];
    logic [63:0]        n_lbt   [NUM_DIRS];
    logic [63:0]        r_time;
    logic [63:0]        n_time;

    logic [NUM_DIRS-1:0] w_timeout;
    logic               w_accept;
    logic               w_pop;
    t_event             w_byte_ev;
    t_result            w_res0;
    t_result            w_res1;
    logic [1:0]         w_nres;

    t_result            r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_cnt > Q_CNT_W'(Q_DEPTH - 2));
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != '0);
    assign w_pop       = o_out_valid && !i_out_stall;

    assign o_event_dir  = r_q[r_rp].dir;
    assign o_event_code = r_q[r_rp].code;
    assign o_last       = r_q[r_rp].last;

    always_comb begin
        for (int k = 0; k < NUM_DIRS; k++) begin
            w_timeout[k] = (r_phase[k] != PH_SYNC1) &&
                           ((i_tick_time_us - r_lbt[k]) > {32'd0, r_timeout});
        end
    end

    // next state
    always_comb begin
        for (int k = 0; k < NUM_DIRS; k++) begin
            n_phase[k] = r_phase[k];
            n_sum[k]   = r_sum[k];
            n_left[k]  = r_left[k];
            n_lbt[k]   = r_lbt[k];
        end
        n_time = r_time;
        if (w_accept) begin
            if (i_req_type == REQ_BYTE) begin
                n_lbt[i_dir] = r_time;
                case (r_phase[i_dir])
                    PH_SYNC1: begin
                        if (i_data_byte == SYNC_BYTE) n_phase[i_dir] = PH_SYNC2;
                    end
                    PH_SYNC2: begin
                        n_phase[i_dir] = (i_data_byte == SYNC_BYTE) ? PH_ID : PH_SYNC1;
                    end
                    PH_ID: begin
                        n_sum[i_dir]   = i_data_byte;
                        n_phase[i_dir] = PH_LEN;
                    end
                    PH_LEN: begin
                        if (i_data_byte < MIN_LEN || i_data_byte > r_max_len) begin
                            n_phase[i_dir] = PH_SYNC1;
                            n_sum[i_dir]   = '0;
                            n_left[i_dir]  = '0;
                        end else begin
                            n_sum[i_dir]   = r_sum[i_dir] + i_data_byte;
                            n_left[i_dir]  = i_data_byte;
                            n_phase[i_dir] = PH_BODY;
                        end
                    end
                    default: begin
                        if (r_left[i_dir] > 8'd1) begin
                            n_sum[i_dir]  = r_sum[i_dir] + i_data_byte;
                            n_left[i_dir] = r_left[i_dir] - 8'd1;
                        end else begin
                            n_phase[i_dir] = PH_SYNC1;
                            n_sum[i_dir]   = '0;
                            n_left[i_dir]  = '0;
                        end
                    end
                endcase
            end else begin
                n_time = i_tick_time_us;
                for (int k = 0; k < NUM_DIRS; k++) begin
                    if (w_timeout[k]) begin
                        n_phase[k] = PH_SYNC1;
                        n_sum[k]   = '0;
                        n_left[k]  = '0;
                    end
                end
            end
        end
    end

    // results
    always_comb begin
        w_byte_ev = EV_NONE;
        case (r_phase[i_dir])
            PH_SYNC1, PH_SYNC2, PH_ID: w_byte_ev = EV_NONE;
            PH_LEN: begin
                if (i_data_byte < MIN_LEN || i_data_byte > r_max_len) w_byte_ev = EV_BADLEN;
            end
            default: begin
                if (r_left[i_dir] <= 8'd1) begin
                    w_byte_ev = (i_data_byte == ~r_sum[i_dir]) ? EV_OK : EV_BADSUM;
                end
            end
        endcase

        w_res0 = '{dir: 1'b0, code: EV_NONE, last: 1'b1};
        w_res1 = '{dir: 1'b1, code: EV_TIMEOUT, last: 1'b1};
        w_nres = 2'd0;
        if (w_accept) begin
            w_nres = 2'd1;
            if (i_req_type == REQ_BYTE) begin
                w_res0 = '{dir: i_dir, code: w_byte_ev, last: 1'b1};
            end else if (w_timeout[0] && w_timeout[1]) begin
                w_res0 = '{dir: 1'b0, code: EV_TIMEOUT, last: 1'b0};
                w_nres = 2'd2;
            end else if (w_timeout[0]) begin
                w_res0 = '{dir: 1'b0, code: EV_TIMEOUT, last: 1'b1};
            end else if (w_timeout[1]) begin
                w_res0 = '{dir: 1'b1, code: EV_TIMEOUT, last: 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MAX_LEN: r_max_len <= i_cfg_data[7:0];
                REG_TIMEOUT: r_timeout <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_DIRS; k++) begin
                r_phase[k] <= PH_SYNC1;
                r_sum[k]   <= '0;
                r_left[k]  <= '0;
                r_lbt[k]   <= '0;
            end
            r_time <= '0;
        end else begin
            for (int k = 0; k < NUM_DIRS; k++) begin
                r_phase[k] <= n_phase[k];
                r_sum[k]   <= n_sum[k];
                r_left[k]  <= n_left[k];
                r_lbt[k]   <= n_lbt[k];
            end
            r_time <= n_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_nres != 2'd0) r_q[r_wp] <= w_res0;
        if (w_nres == 2'd2) r_q[r_wp + Q_PTR_W'(1)] <= w_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_PTR_W'(w_nres);
            if (w_pop) r_rp <= r_rp + Q_PTR_W'(1);
            r_cnt <= r_cnt + Q_CNT_W'(w_nres) - Q_CNT_W'(w_pop);
        end
    end

endmodule

`default_nettype wire

### rtl/sfo_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sfo_checker
    import sfo_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire                  o_event_dir,
    input wire [2:0]            o_event_code,
    input wire                  o_last
);

    // queue comes up empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

    // an accepted transaction with an empty queue shows its result next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid) |=> o_out_valid)
        else $error("no result one cycle after accepted transaction");

    // a quiet result always closes its transaction
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_code == EV_NONE) |-> o_last)
        else $error("event code none without last");

    // a non-last result is the first half of a two-direction timeout
    a_first_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_event_code == EV_TIMEOUT && !o_event_dir))
        else $error("unexpected non-last result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_event_code) && $stable(o_event_dir) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind servo_frame_observer_top sfo_checker u_sfo_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_event_dir  (o_event_dir),
    .o_event_code (o_event_code),
    .o_last       (o_last)
);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import sfo_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(7);
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic        req;
        logic        dir;
        logic [7:0]  data;
        logic [63:0] tick;
        logic [3:0]  gap;
    } t_serial_item;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        in_req = REQ_BYTE;
    logic        in_dir = 1'b0;
    logic [7:0]  in_data = 8'd0;
    logic [63:0] in_tick = 64'd0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        event_dir;
    logic [2:0]  event_code;
    logic        event_last;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    servo_frame_observer_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (in_req),
        .i_dir          (in_dir),
        .i_data_byte    (in_data),
        .i_tick_time_us (in_tick),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_event_dir    (event_dir),
        .o_event_code   (event_code),
        .o_last         (event_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // frame tracker state, mirrors the block
    t_phase      fr_phase [NUM_DIRS] = '{PH_SYNC1, PH_SYNC1};
    logic [7:0]  fr_sum [NUM_DIRS] = '{8'd0, 8'd0};
    logic [7:0]  fr_left [NUM_DIRS] = '{8'd0, 8'd0};
    logic [63:0] fr_seen_us [NUM_DIRS] = '{64'd0, 64'd0};
    logic [63:0] model_now = 64'd0;
    logic [7:0]  cap_len = MAX_LEN_RESET;
    logic [31:0] cap_tmo = TIMEOUT_RESET;

    t_result      awaited_events [$];
    t_serial_item pending_items [$];
    int n_queued = 0;
    int n_accepted = 0;
    int n_errors = 0;

    function automatic void drop_frame(input logic d);
        fr_phase[d] = PH_SYNC1;
        fr_sum[d] = 8'd0;
        fr_left[d] = 8'd0;
    endfunction

    task automatic observe_item(input t_serial_item it);
        t_result     r [NUM_DIRS];
        int          n;
        int          k;
        logic        d;
        logic [7:0]  b;
        logic [7:0]  want_sum;
        logic [63:0] quiet;
        t_event      ev;
        if (it.req == REQ_BYTE) begin
            d = it.dir;
            b = it.data;
            ev = EV_NONE;
            case (fr_phase[d])
                PH_SYNC1: if (b == SYNC_BYTE) fr_phase[d] = PH_SYNC2;
                PH_SYNC2: fr_phase[d] = (b == SYNC_BYTE) ? PH_ID : PH_SYNC1;
                PH_ID: begin
                    fr_sum[d] = b;
                    fr_phase[d] = PH_LEN;
                end
                PH_LEN: begin
                    if (b < MIN_LEN || b > cap_len) begin
                        ev = EV_BADLEN;
                        drop_frame(d);
                    end else begin
                        fr_sum[d] = fr_sum[d] + b;
                        fr_left[d] = b;
                        fr_phase[d] = PH_BODY;
                    end
                end
                default: begin
                    if (fr_left[d] > 8'd1) begin
                        fr_sum[d] = fr_sum[d] + b;
                        fr_left[d] = fr_left[d] - 8'd1;
                    end else begin
                        want_sum = ~fr_sum[d];
                        ev = (b == want_sum) ? EV_OK : EV_BADSUM;
                        drop_frame(d);
                    end
                end
            endcase
            fr_seen_us[d] = model_now;
            r[0].dir = d;
            r[0].code = ev;
            r[0].last = 1'b1;
            awaited_events.push_back(r[0]);
        end else begin
            model_now = it.tick;
            n = 0;
            for (k = 0; k < NUM_DIRS; k++) begin
                quiet = model_now - fr_seen_us[k];
                if (fr_phase[k] != PH_SYNC1 && quiet > {32'd0, cap_tmo}) begin
                    drop_frame(k[0]);
                    r[n].dir = k[0];
                    r[n].code = EV_TIMEOUT;
                    r[n].last = 1'b0;
                    n++;
                end
            end
            if (n == 0) begin
                r[0].dir = 1'b0;
                r[0].code = EV_NONE;
                n = 1;
            end
            r[n - 1].last = 1'b1;
            for (k = 0; k < n; k++)
                awaited_events.push_back(r[k]);
        end
    endtask

    // driver
    t_serial_item cur;
    logic         have_cur = 1'b0;
    logic         offering = 1'b0;
    int           gap_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            offering = 1'b0;
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                observe_item(cur);
                n_accepted++;
                have_cur = 1'b0;
                offering = 1'b0;
            end
            if (!have_cur && pending_items.size() > 0) begin
                cur = pending_items.pop_front();
                have_cur = 1'b1;
                gap_left = int'(cur.gap);
            end
            if (have_cur && !offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    offering = 1'b1;
                    in_req <= cur.req;
                    in_dir <= cur.dir;
                    in_data <= cur.data;
                    in_tick <= cur.tick;
                end
            end
            in_valid <= offering;
        end
    end

    // monitor
    logic    long_hold = 1'b0;
    logic    calm_rx = 1'b0;
    int      rx_wait = 0;
    t_result want;

    always @(posedge clk) begin
        if (!rst_n) begin
            rx_wait = 0;
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (awaited_events.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected transaction, expected none, %s %0d %0d %0d",
                             $time, "got dir/code/last", event_dir, event_code, event_last);
                end else begin
                    want = awaited_events.pop_front();
                    if (event_dir !== want.dir) begin
                        n_errors++;
                        $display("%0t: event_dir expected %0d got %0d", $time, want.dir,
                                 event_dir);
                    end
                    if (event_code !== want.code) begin
                        n_errors++;
                        $display("%0t: event_code expected %0d got %0d", $time, want.code,
                                 event_code);
                    end
                    if (event_last !== want.last) begin
                        n_errors++;
                        $display("%0t: last expected %0d got %0d", $time, want.last,
                                 event_last);
                    end
                end
                rx_wait = calm_rx ? 0 : $urandom_range(0, 12);
                if ($urandom_range(0, 39) == 0)
                    calm_rx = !calm_rx;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            out_stall <= long_hold || (rx_wait > 0);
        end
    end

    // long receiver hold-off so the result queue fills and the input stalls
    initial begin
        @(negedge clk);
        while (n_accepted < HOLD_AT)
            @(negedge clk);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // stimulus generation
    logic        calm_tx = 1'b0;
    logic [63:0] stim_now = 64'd0;
    logic [63:0] gen_tmo = 64'(TIMEOUT_RESET);
    int          gen_max = int'(MAX_LEN_RESET);
    logic        left_open = 1'b0;
    logic [7:0]  lane0 [$];
    logic [7:0]  lane1 [$];
    logic [7:0]  frame_buf [$];

    task automatic queue_item(input logic req, input logic d, input logic [7:0] b,
                              input logic [63:0] t);
        t_serial_item it;
        it.req = req;
        it.dir = d;
        it.data = b;
        it.tick = t;
        it.gap = calm_tx ? 4'd0 : 4'($urandom_range(0, 12));
        if ($urandom_range(0, 49) == 0)
            calm_tx = !calm_tx;
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic add_byte(input logic d, input logic [7:0] b);
        queue_item(REQ_BYTE, d, b, 64'($urandom));
    endtask

    task automatic add_tick_at(input logic [63:0] t);
        stim_now = t;
        queue_item(REQ_TICK, 1'($urandom), 8'($urandom), t);
    endtask

    task automatic add_tick_step();
        int          sel;
        logic [63:0] step;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            step = 64'($urandom_range(0, 40));
        else if (sel == 6)
            step = gen_tmo;
        else if (sel == 7)
            step = gen_tmo + 64'd1;
        else if (sel == 8)
            step = {32'd0, $urandom};
        else
            step = {$urandom, $urandom};
        add_tick_at(stim_now + step);
    endtask

    task automatic lane_push(input logic d, input logic [7:0] b);
        if (d)
            lane1.push_back(b);
        else
            lane0.push_back(b);
    endtask

    task automatic add_frame(input logic d);
        int         kind;
        int         len;
        int         top;
        int         cut;
        int         i;
        logic [7:0] id;
        logic [7:0] csum;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind >= 93) begin
            repeat ($urandom_range(1, 4)) lane_push(d, 8'($urandom));
            return;
        end
        if (kind >= 85) begin
            // lost sync after the first FF
            lane_push(d, SYNC_BYTE);
            lane_push(d, 8'($urandom_range(0, 254)));
            return;
        end
        id = 8'($urandom);
        if (kind >= 70 && kind < 78) begin
            if (gen_max < 255 && $urandom_range(0, 1) == 1)
                len = $urandom_range(gen_max + 1, 255);
            else
                len = $urandom_range(0, 1);
        end else if (gen_max < 2) begin
            len = $urandom_range(2, 8);
        end else begin
            top = ($urandom_range(0, 19) == 0) ? gen_max : ((gen_max < 10) ? gen_max : 10);
            len = $urandom_range(2, top);
        end
        frame_buf.delete();
        frame_buf.push_back(SYNC_BYTE);
        frame_buf.push_back(SYNC_BYTE);
        frame_buf.push_back(id);
        frame_buf.push_back(8'(len));
        if (!(kind >= 70 && kind < 78)) begin
            csum = id + 8'(len);
            for (i = 0; i < len - 1; i++) begin
                b = ($urandom_range(0, 7) == 0) ? SYNC_BYTE : 8'($urandom);
                csum = csum + b;
                frame_buf.push_back(b);
            end
            if (kind >= 60 && kind < 70)
                frame_buf.push_back(~csum ^ 8'($urandom_range(1, 255)));
            else
                frame_buf.push_back(~csum);
        end
        cut = frame_buf.size();
        if (kind >= 78) begin
            cut = $urandom_range(1, frame_buf.size() - 1);
            left_open = 1'b1;
        end
        for (i = 0; i < cut; i++)
            lane_push(d, frame_buf[i]);
    endtask

    task automatic add_round();
        logic d;
        logic [7:0] b;
        left_open = 1'b0;
        if ($urandom_range(0, 4) != 0)
            add_frame(1'b0);
        if ($urandom_range(0, 4) < 3)
            add_frame(1'b1);
        while (lane0.size() + lane1.size() > 0) begin
            if (lane0.size() == 0)
                d = 1'b1;
            else if (lane1.size() == 0)
                d = 1'b0;
            else
                d = 1'($urandom_range(0, 1));
            b = d ? lane1.pop_front() : lane0.pop_front();
            add_byte(d, b);
            if ($urandom_range(0, 11) == 0)
                add_tick_step();
        end
        if (left_open && $urandom_range(0, 3) != 0)
            add_tick_at(stim_now + gen_tmo + 64'd1 + 64'($urandom_range(0, 3)));
        else if ($urandom_range(0, 3) == 0)
            add_tick_step();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MAX_LEN)
            cap_len = val[7:0];
        else if (idx == REG_TIMEOUT)
            cap_tmo = val;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (n_accepted != n_queued || awaited_events.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_phase(input int max_len, input logic [31:0] tmo, input int count,
                             input logic spare);
        int target;
        wait_idle();
        @(posedge clk);
        write_reg(REG_MAX_LEN, CFG_DATA_W'(max_len));
        write_reg(REG_TIMEOUT, tmo);
        if (spare)
            write_reg(REG_SPARE, $urandom);
        cfg_valid <= 1'b0;
        gen_max = max_len;
        gen_tmo = {32'd0, tmo};
        @(negedge clk);
        target = n_queued + count;
        while (n_queued < target)
            add_round();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle tick, clean frame with an all-ones checksum
        add_tick_at(64'd0);
        add_byte(1'b0, SYNC_BYTE);
        add_byte(1'b0, SYNC_BYTE);
        add_byte(1'b0, 8'hFE);
        add_byte(1'b0, 8'h02);
        add_byte(1'b0, 8'h00);
        add_byte(1'b0, 8'hFF);
        // sync loss, then a zero length byte
        add_byte(1'b1, SYNC_BYTE);
        add_byte(1'b1, 8'h00);
        add_byte(1'b0, SYNC_BYTE);
        add_byte(1'b0, SYNC_BYTE);
        add_byte(1'b0, 8'h01);
        add_byte(1'b0, 8'h00);
        // both directions left open: one after the longest length, one after the id byte
        add_byte(1'b0, SYNC_BYTE);
        add_byte(1'b0, SYNC_BYTE);
        add_byte(1'b0, 8'h03);
        add_byte(1'b0, 8'hFF);
        add_byte(1'b1, SYNC_BYTE);
        add_byte(1'b1, SYNC_BYTE);
        add_byte(1'b1, 8'h07);
        add_tick_at(64'(TIMEOUT_RESET));
        add_tick_at(64'(TIMEOUT_RESET) + 64'd1);
        // time going backwards
        add_byte(1'b0, SYNC_BYTE);
        add_tick_at(64'd0);
        add_tick_at('1);

        run_phase(2, 32'd0, 270, 1'b0);
        run_phase(255, 32'hFFFF_FFFF, 270, 1'b0);
        run_phase(1, 32'd30, 60, 1'b1);
        run_phase($urandom_range(3, 40), 32'($urandom_range(10, 3000)), 270, 1'b0);
        run_phase(12, 32'd100, 270, 1'b0);
        run_phase(255, TIMEOUT_RESET, 200, 1'b0);

        wait_idle();
        repeat (20) @(negedge clk);
        if (n_errors == 0)
            $display("servo_frame_observer_top regression: pass");
        else
            $display("servo_frame_observer_top regression: fail");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("servo_frame_observer_top regression: fail");
        $finish;
    end

endmodule
